>>> design/dmp_pkg.sv
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants of the DHCP/BOOTP message parser.
// ----------------------------------------------------------------------------
package dmp_pkg;

  localparam logic [2:0] KIND_HDR_FIELD = 3'd0;
  localparam logic [2:0] KIND_BLOB_BYTE = 3'd1;
  localparam logic [2:0] KIND_OPT_HDR   = 3'd2;
  localparam logic [2:0] KIND_OPT_DATA  = 3'd3;
  localparam logic [2:0] KIND_MSG_END   = 3'd4;

  localparam logic [3:0] FID_GIADDR = 4'd10;
  localparam logic [3:0] FID_CHADDR = 4'd11;
  localparam logic [3:0] FID_SNAME  = 4'd12;
  localparam logic [3:0] FID_FILE   = 4'd13;

  localparam logic [7:0] HEADER_LAST = 8'd27;
  localparam logic [7:0] CHADDR_BASE = 8'd28;
  localparam logic [7:0] SNAME_BASE  = 8'd44;
  localparam logic [7:0] FILE_BASE   = 8'd108;
  localparam logic [7:0] BLOB_LAST   = 8'd235;
  localparam logic [7:0] COOKIE_LAST = 8'd239;
  localparam logic [7:0] OFFSET_MAX  = 8'd255;
  localparam logic [7:0] CODE_PAD    = 8'd0;
  localparam logic [7:0] CODE_END    = 8'd255;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [7:0]  byte_index;
    logic [7:0]  option_code;
    logic [7:0]  option_length;
    logic        truncated;
    logic        last_result;
  } dmp_item_t;

  // last byte offset of each fixed header field, op through giaddr
  function automatic logic [7:0] field_end(input logic [3:0] fid);
    logic [7:0] e;
    unique case (fid)
      4'd0:    e = 8'd0;
      4'd1:    e = 8'd1;
      4'd2:    e = 8'd2;
      4'd3:    e = 8'd3;
      4'd4:    e = 8'd7;
      4'd5:    e = 8'd9;
      4'd6:    e = 8'd11;
      4'd7:    e = 8'd15;
      4'd8:    e = 8'd19;
      4'd9:    e = 8'd23;
      default: e = 8'd27;
    endcase
    return e;
  endfunction

  // header field that the byte at this offset belongs to
  function automatic logic [3:0] header_field(input logic [7:0] off);
    logic [3:0] fid;
    fid = FID_GIADDR;
    for (int i = 9; i >= 0; i--) begin
      if (off <= field_end(4'(i))) begin
        fid = 4'(i);
      end
    end
    return fid;
  endfunction

endpackage

>>> design/dmp_if.sv
// ----------------------------------------------------------------------------
// dmp_in_if / dmp_out_if
// Valid/ready channels for message bytes and parsed result items.
// ----------------------------------------------------------------------------
interface dmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface dmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [3:0]  field_id;
  logic [31:0] field_value;
  logic [7:0]  byte_index;
  logic [7:0]  option_code;
  logic [7:0]  option_length;
  logic        truncated;
  logic        last_result;

  modport source (output valid, output item_kind, output field_id, output field_value,
                  output byte_index, output option_code, output option_length,
                  output truncated, output last_result, input ready);
  modport sink   (input valid, input item_kind, input field_id, input field_value,
                  input byte_index, input option_code, input option_length,
                  input truncated, input last_result, output ready);
endinterface

>>> design/dmp_step.sv
// ----------------------------------------------------------------------------
// dmp_step
// Parse state and per-byte decode: up to one parsed item and one end item.
// ----------------------------------------------------------------------------
module dmp_step
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  logic [7:0] data_byte,
  input  logic      eom,
  output dmp_item_t main_item,
  output logic      main_vld,
  output dmp_item_t end_item,
  output logic      end_vld
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BLOB   = 3'd1,
    PH_COOKIE = 3'd2,
    PH_CODE   = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [7:0]  pos_r, pos_nxt;

  logic [31:0] acc_shift;
  logic [3:0]  hdr_fid;
  logic [7:0]  remain_dec;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    code_nxt   = code_r;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    main_vld   = 1'b0;
    main_item  = '0;
    acc_shift  = {acc_r[23:0], data_byte};
    hdr_fid    = header_field(offset_r);
    remain_dec = remain_r - 8'd1;

    unique case (phase_r)
      PH_HEADER: begin
        acc_nxt = acc_shift;
        if (offset_r == field_end(hdr_fid)) begin
          main_vld              = 1'b1;
          main_item.item_kind   = KIND_HDR_FIELD;
          main_item.field_id    = hdr_fid;
          main_item.field_value = acc_shift;
          acc_nxt               = '0;
        end
        if (offset_r >= HEADER_LAST) phase_nxt = PH_BLOB;
      end
      PH_BLOB: begin
        main_vld              = 1'b1;
        main_item.item_kind   = KIND_BLOB_BYTE;
        main_item.field_value = {24'd0, data_byte};
        if (offset_r < SNAME_BASE) begin
          main_item.field_id   = FID_CHADDR;
          main_item.byte_index = offset_r - CHADDR_BASE;
        end else if (offset_r < FILE_BASE) begin
          main_item.field_id   = FID_SNAME;
          main_item.byte_index = offset_r - SNAME_BASE;
        end else begin
          main_item.field_id   = FID_FILE;
          main_item.byte_index = offset_r - FILE_BASE;
        end
        if (offset_r >= BLOB_LAST) phase_nxt = PH_COOKIE;
      end
      PH_COOKIE: begin
        if (offset_r >= COOKIE_LAST) phase_nxt = PH_CODE;
      end
      PH_CODE: begin
        if (data_byte != CODE_PAD && data_byte != CODE_END) begin
          code_nxt  = data_byte;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        main_vld                = 1'b1;
        main_item.item_kind     = KIND_OPT_HDR;
        main_item.option_code   = code_r;
        main_item.option_length = data_byte;
        if (data_byte == 8'd0) begin
          phase_nxt = PH_CODE;
        end else begin
          remain_nxt = data_byte;
          pos_nxt    = '0;
          phase_nxt  = PH_DATA;
        end
      end
      PH_DATA: begin
        main_vld                = 1'b1;
        main_item.item_kind     = KIND_OPT_DATA;
        main_item.field_value   = {24'd0, data_byte};
        main_item.byte_index    = pos_r;
        main_item.option_code   = code_r;
        main_item.option_length = pos_r + remain_r;
        pos_nxt                 = pos_r + 8'd1;
        remain_nxt              = remain_dec;
        if (remain_dec == 8'd0) phase_nxt = PH_CODE;
      end
      default: begin
        phase_nxt = PH_CODE;
      end
    endcase

    offset_nxt = (offset_r < OFFSET_MAX) ? offset_r + 8'd1 : offset_r;

    main_item.last_result = !eom;
    end_vld               = eom;
    end_item              = '0;
    end_item.item_kind    = KIND_MSG_END;
    end_item.truncated    = (phase_nxt != PH_CODE);
    end_item.last_result  = 1'b1;

    if (eom) begin
      phase_nxt  = PH_HEADER;
      offset_nxt = '0;
      acc_nxt    = '0;
      code_nxt   = '0;
      remain_nxt = '0;
      pos_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      offset_r <= '0;
      acc_r    <= '0;
      code_r   <= '0;
      remain_r <= '0;
      pos_r    <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      acc_r    <= acc_nxt;
      code_r   <= code_nxt;
      remain_r <= remain_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

>>> design/dmp_out_queue.sv
// ----------------------------------------------------------------------------
// dmp_out_queue
// Four-entry result queue, takes up to two items a cycle, drains one a cycle while rd_ready is high.
// ----------------------------------------------------------------------------
module dmp_out_queue
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_a_vld,
  input  dmp_item_t wr_a,
  input  logic      wr_b_vld,
  input  dmp_item_t wr_b,
  output logic      room2,
  output logic      rd_vld,
  output dmp_item_t rd_item,
  input  logic      rd_ready
);

  dmp_item_t  q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic       pop;
  logic [2:0] push_n;
  dmp_item_t  first_item;
  logic [1:0] wr_ptr_p1;

  always_comb begin
    rd_vld     = (cnt_r != 3'd0);
    rd_item    = q_r[rd_ptr_r];
    room2      = (cnt_r <= 3'd2);
    pop        = rd_vld && rd_ready;
    push_n     = {2'd0, wr_a_vld} + {2'd0, wr_b_vld};
    first_item = wr_a_vld ? wr_a : wr_b;
    wr_ptr_p1  = wr_ptr_r + 2'd1;
    wr_ptr_nxt = wr_ptr_r + push_n[1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + push_n - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 3'd0) q_r[wr_ptr_r] <= first_item;
    if (push_n == 3'd2) q_r[wr_ptr_p1] <= wr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/dhcp_message_parser_core.sv
// path: an accepted byte is registered in the input stage, then decoded, and its results
//   are written to the result queue, from which out_ch is driven
// throughput: one message byte per cycle while the queue has room; a final byte that also yields a parsed
//   item puts two results in the queue, drained one per cycle while out_ch.ready is high
// input is held off only while the four-entry result queue lacks room for two
// reset: synchronous active-low rst_n empties the queue and resets the parser
// ----------------------------------------------------------------------------
// dhcp_message_parser_core
// DHCP/BOOTP byte-stream parser: header fields, blob bytes, options, end item.
// ----------------------------------------------------------------------------
module dhcp_message_parser_core
  import dmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dmp_in_if.sink    in_ch,
  dmp_out_if.source out_ch
);

  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eom_r;

  logic       go;
  logic       room2;
  logic       accept;
  dmp_item_t  main_item, end_item, rd_item;
  logic       main_vld, end_vld, rd_vld;

  assign go           = s1_vld_r && room2;
  assign in_ch.ready  = !s1_vld_r || go;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eom_r  <= in_ch.end_of_message;
    end
  end

  dmp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .data_byte (s1_byte_r),
    .eom       (s1_eom_r),
    .main_item (main_item),
    .main_vld  (main_vld),
    .end_item  (end_item),
    .end_vld   (end_vld)
  );

  dmp_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_a_vld (go && main_vld),
    .wr_a     (main_item),
    .wr_b_vld (go && end_vld),
    .wr_b     (end_item),
    .room2    (room2),
    .rd_vld   (rd_vld),
    .rd_item  (rd_item),
    .rd_ready (out_ch.ready)
  );

  assign out_ch.valid         = rd_vld;
  assign out_ch.item_kind     = rd_item.item_kind;
  assign out_ch.field_id      = rd_item.field_id;
  assign out_ch.field_value   = rd_item.field_value;
  assign out_ch.byte_index    = rd_item.byte_index;
  assign out_ch.option_code   = rd_item.option_code;
  assign out_ch.option_length = rd_item.option_length;
  assign out_ch.truncated     = rd_item.truncated;
  assign out_ch.last_result   = rd_item.last_result;

endmodule

>>> design/dmp_checker.sv
// ----------------------------------------------------------------------------
// dmp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dmp_checker
  import dmp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_item_kind,
  input logic [3:0]  out_field_id,
  input logic [31:0] out_field_value,
  input logic        out_truncated,
  input logic        out_last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_value)
      && $stable(out_item_kind))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_MSG_END |-> out_last_result)
    else $error("end item not marked last");

  a_trunc_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind != KIND_MSG_END |-> !out_truncated)
    else $error("truncated flag on a non-end item");

  a_hdr_fid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind == KIND_HDR_FIELD |-> out_field_id <= FID_GIADDR)
    else $error("header item with blob field id");

endmodule

bind dhcp_message_parser_core dmp_checker u_dmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_item_kind   (out_ch.item_kind),
  .out_field_id    (out_ch.field_id),
  .out_field_value (out_ch.field_value),
  .out_truncated   (out_ch.truncated),
  .out_last_result (out_ch.last_result)
);

>>> tb/sv/dhcp_message_parser_checker.sv
// ----------------------------------------------------------------------------
// dhcp_message_parser_checker
// Watches the byte and result channels of the DHCP/BOOTP parser. Each accepted
// byte runs through a local parser model that queues the items it should give;
// each accepted result is compared field by field with the oldest queued item.
// ----------------------------------------------------------------------------
module dhcp_message_parser_checker
  import dmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dmp_in_if         bytes_mon,
  dmp_out_if        items_mon,
  output int        mismatches,
  output int        items_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HEADER, ST_BLOB, ST_COOKIE, ST_CODE, ST_LENGTH, ST_DATA
  } parse_state_t;

  localparam logic [7:0] HDR_FIELD_END [11] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd7, 8'd9, 8'd11, 8'd15, 8'd19, 8'd23, HEADER_LAST
  };

  logic [7:0]   msg_offset;
  parse_state_t state;
  logic [31:0]  hdr_acc;
  logic [7:0]   opt_code;
  logic [7:0]   opt_left;
  logic [7:0]   opt_pos;
  dmp_item_t    parsed_items[$];
  dmp_item_t    oldest;
  int           fail_count = 0;
  int           pending_count = 0;

  assign mismatches    = fail_count;
  assign items_pending = pending_count;

  function automatic void reset_parser();
    msg_offset = '0;
    state      = ST_HEADER;
    hdr_acc    = '0;
    opt_code   = '0;
    opt_left   = '0;
    opt_pos    = '0;
  endfunction

  function automatic dmp_item_t make_item(input logic [2:0] kind, input logic [3:0] fid,
                                          input logic [31:0] val, input logic [7:0] idx,
                                          input logic [7:0] code, input logic [7:0] len,
                                          input logic trunc);
    dmp_item_t it;
    it.item_kind     = kind;
    it.field_id      = fid;
    it.field_value   = val;
    it.byte_index    = idx;
    it.option_code   = code;
    it.option_length = len;
    it.truncated     = trunc;
    it.last_result   = 1'b0;
    return it;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    dmp_item_t made[$];
    case (state)
      ST_HEADER: begin
        hdr_acc = {hdr_acc[23:0], b};
        for (int i = 0; i < 11; i++) begin
          if (msg_offset == HDR_FIELD_END[i]) begin
            made = {made, make_item(KIND_HDR_FIELD, 4'(i), hdr_acc, '0, '0, '0, 1'b0)};
            hdr_acc = '0;
          end
        end
        if (msg_offset >= HEADER_LAST) state = ST_BLOB;
      end
      ST_BLOB: begin
        if (msg_offset < SNAME_BASE)
          made = {made, make_item(KIND_BLOB_BYTE, FID_CHADDR, {24'd0, b},
                                  msg_offset - CHADDR_BASE, '0, '0, 1'b0)};
        else if (msg_offset < FILE_BASE)
          made = {made, make_item(KIND_BLOB_BYTE, FID_SNAME, {24'd0, b},
                                  msg_offset - SNAME_BASE, '0, '0, 1'b0)};
        else
          made = {made, make_item(KIND_BLOB_BYTE, FID_FILE, {24'd0, b},
                                  msg_offset - FILE_BASE, '0, '0, 1'b0)};
        if (msg_offset >= BLOB_LAST) state = ST_COOKIE;
      end
      ST_COOKIE: begin
        if (msg_offset >= COOKIE_LAST) state = ST_CODE;
      end
      ST_CODE: begin
        if (b != CODE_PAD && b != CODE_END) begin
          opt_code = b;
          state    = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        made = {made, make_item(KIND_OPT_HDR, '0, '0, '0, opt_code, b, 1'b0)};
        if (b == 8'd0) begin
          state = ST_CODE;
        end else begin
          opt_left = b;
          opt_pos  = '0;
          state    = ST_DATA;
        end
      end
      ST_DATA: begin
        made = {made, make_item(KIND_OPT_DATA, '0, {24'd0, b}, opt_pos, opt_code,
                                opt_pos + opt_left, 1'b0)};
        opt_pos  = opt_pos + 8'd1;
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) state = ST_CODE;
      end
      default: state = ST_CODE;
    endcase
    if (msg_offset != OFFSET_MAX) msg_offset = msg_offset + 8'd1;
    if (eom) begin
      made = {made, make_item(KIND_MSG_END, '0, '0, '0, '0, '0, state != ST_CODE)};
      reset_parser();
    end
    if (made.size() > 0) made[made.size() - 1].last_result = 1'b1;
    parsed_items = {parsed_items, made};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_parser();
      parsed_items.delete();
    end else begin
      if (items_mon.valid && items_mon.ready) begin
        if (parsed_items.size() == 0) begin
          $error("result transaction with none expected: item_kind %0d", items_mon.item_kind);
          fail_count++;
        end else begin
          oldest = parsed_items.pop_front();
          check_field("item_kind", oldest.item_kind, items_mon.item_kind);
          check_field("field_id", oldest.field_id, items_mon.field_id);
          check_field("field_value", oldest.field_value, items_mon.field_value);
          check_field("byte_index", oldest.byte_index, items_mon.byte_index);
          check_field("option_code", oldest.option_code, items_mon.option_code);
          check_field("option_length", oldest.option_length, items_mon.option_length);
          check_field("truncated", oldest.truncated, items_mon.truncated);
          check_field("last_result", oldest.last_result, items_mon.last_result);
        end
      end
      if (bytes_mon.valid && bytes_mon.ready)
        parse_byte(bytes_mon.data_byte, bytes_mon.end_of_message);
    end
    pending_count = parsed_items.size();
  end

endmodule

>>> tb/sv/dhcp_message_parser_core_test.sv
// ----------------------------------------------------------------------------
// dhcp_message_parser_core_test
// Feeds the DHCP/BOOTP parser short directed messages, then random messages:
// mostly full headers with random options, some cut short, some noise. Both
// channels idle at random; the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module dhcp_message_parser_core_test;
  import dmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BYTES   = 1250;
  localparam int FIXED_PART_LEN = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dmp_in_if  msg_in();
  dmp_out_if parsed_out();

  int         fail_count;
  int         pending_count;
  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  int         hold_asks = 0;
  int         holds_done = 0;
  int         hold_left = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  logic [7:0] msg_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dhcp_message_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (msg_in),
    .out_ch (parsed_out)
  );

  dhcp_message_parser_checker parse_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .bytes_mon     (msg_in),
    .items_mon     (parsed_out),
    .mismatches    (fail_count),
    .items_pending (pending_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    parsed_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        parsed_out.ready = 1'b0;
        hold_left--;
      end else begin
        parsed_out.ready = !(sink_gaps && $urandom_range(99) < 36);
      end
    end
  end

  function automatic logic [7:0] random_octet();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_msg_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (src_gaps && $urandom_range(99) < 36) begin
      @(negedge clk);
      msg_in.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    msg_in.valid          = 1'b1;
    msg_in.data_byte      = b;
    msg_in.end_of_message = last;
    do @(posedge clk); while (msg_in.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[k]) send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
  endtask

  // stop offering bytes until every queued item has come out
  task automatic drain();
    @(negedge clk);
    msg_in.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic build_bootp();
    int n_opts;
    int r;
    int len;
    msg_bytes.delete();
    repeat (FIXED_PART_LEN) add_msg_byte(random_octet());
    n_opts = $urandom_range(1, 10);
    repeat (n_opts) begin
      r = $urandom_range(99);
      if (r < 10) begin
        add_msg_byte(CODE_PAD);
      end else if (r < 20) begin
        add_msg_byte(CODE_END);
      end else begin
        add_msg_byte(8'($urandom_range(1, 254)));
        r = $urandom_range(99);
        if (r < 20) len = 0;
        else if (r < 24) len = $urandom_range(200, 255);
        else len = $urandom_range(1, 16);
        add_msg_byte(8'(len));
        repeat (len) add_msg_byte(random_octet());
      end
    end
  endtask

  task automatic cut_message(input int keep);
    while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
  endtask

  initial begin
    int msg_count;
    int r;
    int target;
    msg_in.valid          = 1'b0;
    msg_in.data_byte      = 8'h00;
    msg_in.end_of_message = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: one-byte messages, all-ones and all-zeros header fields
    msg_bytes = '{8'hFF};
    send_message();
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg_bytes = '{8'h00, 8'h01, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h80, 8'h01, 8'h00, 8'hFF};
    send_message();
    drain();

    msg_count = 0;
    target    = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      build_bootp();
      if (r >= 92) begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 30)) add_msg_byte(8'($urandom_range(255)));
      end else if (r >= 80) begin
        cut_message($urandom_range(1, FIXED_PART_LEN));
      end else if (r >= 55) begin
        cut_message($urandom_range(FIXED_PART_LEN + 1, msg_bytes.size()));
      end
      src_gaps  = (msg_count != 2);
      sink_gaps = (msg_count != 2);
      if (msg_count == 0) hold_asks++;
      send_message();
      if (msg_count == 3) drain();
      msg_count++;
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
